### hw/rtl/msst_pkg.sv
// Package for the multi-slot software timer: sizes, opcodes, controller
// state type and the command struct between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package msst_pkg;

  // Bank size and counter width
  localparam int NUM_SLOTS   = 8;
  localparam int COUNT_WIDTH = 32;

  // Field widths fixed by the item format
  localparam int TICKS_W   = 32;
  localparam int SIDX_W    = 3;
  localparam int FMASK_W   = 8;
  localparam int IN_DATA_W = 64;
  localparam int OUT_DATA_W = 16;

  // Derived widths
  localparam int IDX_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int IDX_EXT_W  = (IDX_W > SIDX_W) ? IDX_W : SIDX_W;
  localparam int FIRE_EXT_W = (NUM_SLOTS > FMASK_W) ? NUM_SLOTS : FMASK_W;
  localparam int CNT_EXT_W  = (COUNT_WIDTH > TICKS_W) ? COUNT_WIDTH : TICKS_W;

  // Item kinds carried in tuser
  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  // Output register state
  typedef enum logic {
    ST_EMPTY,
    ST_FULL
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic do_add;
    logic do_tick;
  } cmd_t;

endpackage : msst_pkg

`default_nettype wire

### hw/rtl/msst_ctrl.sv
// Controller for the timer bank: handshakes on both streams and the
// output register state; issues add/tick commands. Depends on msst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module msst_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic          in_op,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output msst_pkg::cmd_t     cmd
);
  import msst_pkg::*;

  state_t state, state_next;
  logic   accept;
  logic   taken;

  assign in_ready = (state == ST_EMPTY) || out_ready;
  assign accept   = in_valid && in_ready;
  assign taken    = (state == ST_FULL) && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_EMPTY;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_EMPTY: begin
        if (accept) state_next = ST_FULL;
      end
      ST_FULL: begin
        if (taken && !accept) state_next = ST_EMPTY;
      end
      default: state_next = ST_EMPTY;
    endcase
  end

  always_comb begin
    out_valid   = 1'b0;
    cmd.do_add  = 1'b0;
    cmd.do_tick = 1'b0;
    unique case (state)
      ST_EMPTY: out_valid = 1'b0;
      ST_FULL:  out_valid = 1'b1;
      default:  out_valid = 1'b0;
    endcase
    if (accept) begin
      cmd.do_add  = (op_t'(in_op) == OP_ADD);
      cmd.do_tick = (op_t'(in_op) == OP_TICK);
    end
  end

endmodule : msst_ctrl

`default_nettype wire

### hw/rtl/msst_dp.sv
// Datapath for the timer bank: per-slot active/period/count registers,
// lowest-free-slot encoder, parallel tick lanes and result register.
// Depends on msst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module msst_dp (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire msst_pkg::cmd_t              cmd,
  input  wire logic [msst_pkg::TICKS_W-1:0] delay_ticks,
  input  wire logic [msst_pkg::TICKS_W-1:0] period_ticks,
  output logic                             add_ok,
  output logic [msst_pkg::SIDX_W-1:0]      slot_index,
  output logic [msst_pkg::FMASK_W-1:0]     fired_mask,
  output logic [msst_pkg::NUM_SLOTS-1:0]   active_mask
);
  import msst_pkg::*;

  logic [NUM_SLOTS-1:0]   slot_active;
  logic [COUNT_WIDTH-1:0] slot_period    [NUM_SLOTS];
  logic [COUNT_WIDTH-1:0] slot_remaining [NUM_SLOTS];

  logic [NUM_SLOTS-1:0]   free_vec;
  logic [NUM_SLOTS-1:0]   grant;
  logic                   found;
  logic [IDX_W-1:0]       free_idx;
  logic [IDX_EXT_W-1:0]   idx_ext;
  logic [NUM_SLOTS-1:0]   fire;
  logic [FIRE_EXT_W-1:0]  fire_ext;
  logic [COUNT_WIDTH-1:0] rem_dec        [NUM_SLOTS];
  logic [COUNT_WIDTH-1:0] delay_cnt;
  logic [COUNT_WIDTH-1:0] period_cnt;

  assign active_mask = slot_active;

  // Lowest free slot: isolate the lowest set bit, then encode it
  assign free_vec = ~slot_active;
  assign grant    = free_vec & (~free_vec + NUM_SLOTS'(1));
  assign found    = |free_vec;

  always_comb begin
    free_idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (free_vec[i]) free_idx = IDX_W'(i);
    end
  end

  assign idx_ext    = IDX_EXT_W'(free_idx);
  assign delay_cnt  = COUNT_WIDTH'(CNT_EXT_W'(delay_ticks));
  assign period_cnt = COUNT_WIDTH'(CNT_EXT_W'(period_ticks));

  // Tick lanes: decrement a nonzero count, fire when it reaches or sits at zero
  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      rem_dec[i] = (slot_remaining[i] != '0) ? slot_remaining[i] - COUNT_WIDTH'(1)
                                             : slot_remaining[i];
      fire[i]    = slot_active[i] && (rem_dec[i] == '0);
    end
  end

  assign fire_ext = FIRE_EXT_W'(fire);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_active <= '0;
    end else begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (cmd.do_add && grant[i]) begin
          slot_active[i] <= 1'b1;
        end else if (cmd.do_tick && fire[i] && slot_period[i] == '0) begin
          slot_active[i] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (cmd.do_add && grant[i]) begin
        slot_remaining[i] <= delay_cnt;
        slot_period[i]    <= period_cnt;
      end else if (cmd.do_tick && slot_active[i]) begin
        slot_remaining[i] <= fire[i] ? slot_period[i] : rem_dec[i];
      end
    end
  end

  // Result register, loaded once per accepted item
  always_ff @(posedge clk) begin
    if (cmd.do_add) begin
      add_ok     <= found;
      slot_index <= found ? idx_ext[SIDX_W-1:0] : '0;
      fired_mask <= '0;
    end else if (cmd.do_tick) begin
      add_ok     <= 1'b0;
      slot_index <= '0;
      fired_mask <= fire_ext[FMASK_W-1:0];
    end
  end

endmodule : msst_dp

`default_nettype wire

### hw/rtl/multi_slot_software_timer_top.sv
// Top level of the multi-slot software timer bank: stream ports, controller
// and datapath. Depends on msst_pkg, msst_ctrl and msst_dp.
`timescale 1ns / 1ps
`default_nettype none

// Bank of NUM_SLOTS timer slots (eight as built). An add item (tuser = 0)
// claims the lowest free slot with a delay and a reload period and answers
// add_ok and the slot index; with every slot busy it answers add_ok = 0 and
// changes nothing. A tick item (tuser = 1) steps every active slot at once:
// a nonzero count counts down, and a slot whose count reaches or sits at zero
// fires, reloading from its period, or freeing itself when the period is
// zero. The tick answers a mask of fired slots. Every item gives exactly one
// result item. Each item is finished in the cycle it is accepted, since all
// slot lanes and the free-slot priority encoder update in parallel; the
// result sits in a single output register, and a new item is taken in the
// same cycle that the held result is taken, so the block runs at one item
// per cycle unless m_axis_tready stalls; a result is valid in the cycle
// after its item is accepted. Reset clears all slots; no clearing pass.
module multi_slot_software_timer_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,  // [31:0] delay_ticks, [63:32] period_ticks
  input  wire logic        s_axis_tuser,  // [0] op (0 add, 1 tick)
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata   // [0] add_ok, [3:1] slot_index,
                                          // [11:4] fired_mask, [15:12] zero
);
  import msst_pkg::*;

  cmd_t                 cmd;
  logic                 add_ok;
  logic [SIDX_W-1:0]    slot_index;
  logic [FMASK_W-1:0]   fired_mask;
  logic [NUM_SLOTS-1:0] active_mask;

  // Handshakes and output register occupancy
  msst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_op     (s_axis_tuser),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd)
  );

  // Slot state and result register
  msst_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .delay_ticks  (s_axis_tdata[TICKS_W-1:0]),
    .period_ticks (s_axis_tdata[IN_DATA_W-1:TICKS_W]),
    .add_ok       (add_ok),
    .slot_index   (slot_index),
    .fired_mask   (fired_mask),
    .active_mask  (active_mask)
  );

  assign m_axis_tdata = OUT_DATA_W'({fired_mask, slot_index, add_ok});

  // Assertions

  // An add into a full bank must report failure
  a_full_add_fails: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_ADD && (&active_mask))
      |=> (m_axis_tvalid && !m_axis_tdata[0]))
    else $error("add into a full bank reported success");

  // A successful add leaves the claimed slot active
  a_add_sets_active: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_ADD && !(&active_mask))
      |=> ($countones(active_mask) == $countones($past(active_mask)) + 1))
    else $error("add did not claim exactly one slot");

  // A tick never activates a slot
  a_tick_no_new_slot: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_TICK)
      |=> ((active_mask & ~$past(active_mask)) == '0))
    else $error("tick activated a slot");

  // Results of a failed add or of a tick carry slot index zero
  a_index_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[3:1] == '0))
    else $error("slot index set without a successful add");

endmodule : multi_slot_software_timer_top

`default_nettype wire

### sim/tb_top.sv
// Testbench for the multi-slot software timer bank: directed table, then random
// add/tick items under varied stream backpressure, checked against a local model.
// Depends on msst_pkg and multi_slot_software_timer_top.
`timescale 1ns / 1ps

module tb_top;
  import msst_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DIR_ROWS    = 19;
  localparam int DRAIN_CYCLES = 8;

  // One result item as packed in m_axis_tdata[11:0]: add_ok lowest
  typedef struct packed {
    logic [7:0] fired_mask;
    logic [2:0] slot_index;
    logic       add_ok;
  } timer_result_t;

  // Directed row: typed = 1 means want holds the expected result
  typedef struct packed {
    op_t           op;
    logic [31:0]   dly;
    logic [31:0]   per;
    logic          typed;
    timer_result_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;  // [31:0] delay_ticks, [63:32] period_ticks
  logic        s_axis_tuser = 1'b0;  // [0] op
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;  // [0] add_ok, [3:1] slot_index, [11:4] fired_mask

  // Local copy of the timer bank
  logic                   slot_busy   [NUM_SLOTS];
  logic [COUNT_WIDTH-1:0] slot_reload [NUM_SLOTS];
  logic [COUNT_WIDTH-1:0] slot_left   [NUM_SLOTS];

  timer_result_t pending_results[$];
  stim_row_t     dir_rows [DIR_ROWS];

  // Typed expectation for the item currently on the slave side
  logic          cur_typed = 1'b0;
  timer_result_t cur_want  = '0;

  int send_idle_pct = 27;
  int recv_idle_pct = 52;
  int cycle_count   = 0;
  int err_count     = 0;
  int n_items = 0, n_placed = 0, n_refused = 0, n_ticks = 0, n_expiries = 0;

  multi_slot_software_timer_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Advance the bank by one item and return the result it answers
  function automatic timer_result_t step_timer_bank(op_t op, logic [31:0] dly,
                                                    logic [31:0] per);
    timer_result_t          r;
    logic [FIRE_EXT_W-1:0]  fired;
    logic                   found;
    r     = '0;
    fired = '0;
    found = 1'b0;
    if (op == OP_ADD) begin
      // lowest free slot wins; full bank leaves everything alone
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (!found && !slot_busy[i]) begin
          found          = 1'b1;
          slot_busy[i]   = 1'b1;
          slot_left[i]   = dly;
          slot_reload[i] = per;
          r.add_ok       = 1'b1;
          r.slot_index   = 3'(i);
        end
      end
    end else begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (slot_busy[i]) begin
          if (slot_left[i] != '0) slot_left[i] = slot_left[i] - 1'b1;
          // zero delay lands here on the first tick without counting
          if (slot_left[i] == '0) begin
            fired[i] = 1'b1;
            if (slot_reload[i] != '0) slot_left[i] = slot_reload[i];
            else slot_busy[i] = 1'b0;
          end
        end
      end
    end
    r.fired_mask = fired[7:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h (cycle %0d)",
             what, got, want, cycle_count);
    err_count++;
  endtask

  // Results are checked before the item of the same edge is predicted, so a
  // result can never match an item accepted in its own cycle.
  always @(posedge clk) begin : monitor
    timer_result_t got;
    timer_result_t want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[11:0];
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing outstanding", 32'(got), 32'h0);
        end else begin
          want = pending_results.pop_front();
          if (got.add_ok !== want.add_ok)
            report_mismatch("add_ok", 32'(got.add_ok), 32'(want.add_ok));
          if (got.slot_index !== want.slot_index)
            report_mismatch("slot_index", 32'(got.slot_index), 32'(want.slot_index));
          if (got.fired_mask !== want.fired_mask)
            report_mismatch("fired_mask", 32'(got.fired_mask), 32'(want.fired_mask));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = step_timer_bank(op_t'(s_axis_tuser), s_axis_tdata[31:0],
                               s_axis_tdata[63:32]);
        if (cur_typed) want = cur_want;
        pending_results.push_back(want);
        n_items++;
        if (op_t'(s_axis_tuser) == OP_TICK) n_ticks++;
        else if (want.add_ok) n_placed++;
        else n_refused++;
        n_expiries += $countones(want.fired_mask);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("status: fail");
      $finish;
    end
  end

  // Result side backpressure
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Entered and left at a falling edge; valid stays high between
  // back-to-back items.
  task automatic send_item(op_t op, logic [31:0] dly, logic [31:0] per,
                           logic typed, timer_result_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {per, dly};
    cur_typed = typed;
    cur_want  = want;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Periodic slots never free up, so they are capped to keep slots cycling.
  // Adds into a full bank carry full-range values since they change nothing.
  task automatic send_random(int count);
    op_t         op;
    logic [31:0] dly;
    logic [31:0] per;
    int          busy;
    int          periodic;
    for (int k = 0; k < count; k++) begin
      busy     = 0;
      periodic = 0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (slot_busy[i]) begin
          busy++;
          if (slot_reload[i] != '0) periodic++;
        end
      end
      if ($urandom_range(99) < 55) begin
        op  = OP_TICK;
        dly = $urandom;  // ignored by a tick
        per = $urandom;
      end else begin
        op = OP_ADD;
        if (busy == NUM_SLOTS) begin
          dly = $urandom;
          per = $urandom;
        end else begin
          dly = $urandom_range(12, 0);
          per = (periodic < 5 && $urandom_range(99) < 10) ? $urandom_range(9, 1) : 0;
        end
      end
      send_item(op, dly, per, 1'b0, '0);
    end
  endtask

  initial begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_busy[i]   = 1'b0;
      slot_reload[i] = '0;
      slot_left[i]   = '0;
    end

    // Directed table. Slot 1 ends up parked with the all-ones delay for the
    // whole run; slot 0 is periodic from here on.
    dir_rows = '{
      '{OP_TICK, 32'h0000_0000, 32'h0000_0000, 1'b1, '{8'h00, 3'd0, 1'b0}},  // idle bank
      '{OP_ADD,  32'h0000_0000, 32'h0000_0000, 1'b1, '{8'h00, 3'd0, 1'b1}},  // zero delay
      '{OP_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{8'h01, 3'd0, 1'b0}},  // fires, freed
      '{OP_TICK, 32'h0000_0000, 32'h0000_0000, 1'b1, '{8'h00, 3'd0, 1'b0}},
      '{OP_ADD,  32'h0000_0000, 32'h0000_0002, 1'b1, '{8'h00, 3'd0, 1'b1}},  // periodic
      '{OP_ADD,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{8'h00, 3'd1, 1'b1}},  // extremes
      '{OP_ADD,  32'h0000_0001, 32'h0000_0000, 1'b1, '{8'h00, 3'd2, 1'b1}},
      '{OP_ADD,  32'h0000_0002, 32'h0000_0000, 1'b1, '{8'h00, 3'd3, 1'b1}},
      '{OP_ADD,  32'h0000_0003, 32'h0000_0000, 1'b1, '{8'h00, 3'd4, 1'b1}},
      '{OP_ADD,  32'h0000_0001, 32'h0000_0000, 1'b1, '{8'h00, 3'd5, 1'b1}},
      '{OP_ADD,  32'h0000_0004, 32'h0000_0000, 1'b1, '{8'h00, 3'd6, 1'b1}},
      '{OP_ADD,  32'h0000_0002, 32'h0000_0000, 1'b1, '{8'h00, 3'd7, 1'b1}},
      '{OP_ADD,  32'h0000_0001, 32'h0000_0001, 1'b1, '{8'h00, 3'd0, 1'b0}},  // bank full
      '{OP_TICK, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b0, '0},
      '{OP_ADD,  32'h0000_0000, 32'h0000_0000, 1'b0, '0},
      '{OP_TICK, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
      '{OP_TICK, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
      '{OP_TICK, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
      '{OP_TICK, 32'h0000_0000, 32'h0000_0000, 1'b0, '0}
    };

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIR_ROWS; r++)
      send_item(dir_rows[r].op, dir_rows[r].dly, dir_rows[r].per,
                dir_rows[r].typed, dir_rows[r].want);

    send_random(200);

    // hold off the sender until the bank has answered everything
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);

    send_idle_pct = 52;
    recv_idle_pct = 27;
    send_random(200);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(200);

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("ran %0d items: %0d ticks with %0d slot expiries, %0d adds placed",
             n_items, n_ticks, n_expiries, n_placed);
    $display("and %0d adds turned away by a full bank; %0d mismatches",
             n_refused, err_count);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### multi_slot_software_timer_top.f
hw/rtl/msst_pkg.sv
hw/rtl/msst_ctrl.sv
hw/rtl/msst_dp.sv
hw/rtl/multi_slot_software_timer_top.sv
sim/tb_top.sv
